// ----- sv/osm_pkg.sv -----
// ----------------------------------------------------------------------------
// osm_pkg
// shared types and constants of the order-statistic multiset core
// ----------------------------------------------------------------------------
package osm_pkg;

   localparam int DIST_ENTRIES = 64;
   localparam int CNT_W        = 16;
   localparam int IDX_W        = $clog2(DIST_ENTRIES);
   localparam int USED_W       = $clog2(DIST_ENTRIES + 1);
   localparam int VAL_W        = 32;

   localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
   localparam logic signed [VAL_W-1:0] NO_ABOVE = 32'sd2147483647;
   localparam logic signed [VAL_W-1:0] NO_BELOW = -32'sd2147483647;

   typedef enum logic [2:0] {
      CMD_RANK   = 3'd0,
      CMD_KTH    = 3'd1,
      CMD_PREV   = 3'd2,
      CMD_NEXT   = 3'd3,
      CMD_INSERT = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_DROP  = 2'd1,
      ST_RANGE = 2'd2
   } stat_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic              load;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
      logic              eval;
      logic [USED_W-1:0] eval_idx;
      logic              shift_wr;
      logic [IDX_W-1:0]  wr_addr;
      logic              bump;
      logic              put;
      logic              drop;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic [USED_W-1:0] used;
      logic [USED_W-1:0] pos;
      logic              is_insert;
      logic              ins_drop;
      logic              ins_eq;
   } sts_type;

endpackage

// ----- sv/osm_dpath.sv -----
// ----------------------------------------------------------------------------
// osm_dpath
// value and count tables, scan accumulators and the answer register
// ----------------------------------------------------------------------------
module osm_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  osm_pkg::ctl_type              ctl,
   input  logic [2:0]                    cmd_in,
   input  logic signed [osm_pkg::VAL_W-1:0] x_in,
   output osm_pkg::sts_type              sts,
   output logic [osm_pkg::VAL_W-1:0]     answer,
   output logic [1:0]                    status
);

   // table storage
   logic signed [osm_pkg::VAL_W-1:0] val_mem [osm_pkg::DIST_ENTRIES];
   logic [osm_pkg::CNT_W-1:0]        cnt_mem [osm_pkg::DIST_ENTRIES];
   logic signed [osm_pkg::VAL_W-1:0] rd_val_ff;
   logic [osm_pkg::CNT_W-1:0]        rd_cnt_ff;

   logic [osm_pkg::USED_W-1:0] used_ff, used_in;
   logic [osm_pkg::CNT_W-1:0]  total_ff, total_in;

   logic [2:0]                       op_ff, op_in;
   logic signed [osm_pkg::VAL_W-1:0] x_ff, x_in_r;
   logic [osm_pkg::CNT_W-1:0]        acc_ff, acc_in;
   logic signed [osm_pkg::VAL_W-1:0] ans_ff, ans_in;
   logic [1:0]                       stat_ff, stat_in;
   logic                             found_ff, found_in;
   logic [osm_pkg::USED_W-1:0]       pos_ff, pos_in;
   logic                             eq_ff, eq_in;
   logic [osm_pkg::CNT_W-1:0]        eqcnt_ff, eqcnt_in;

   logic [osm_pkg::CNT_W:0] sum_ext;
   logic [osm_pkg::CNT_W:0] k_ext;
   logic                    range_bad;
   logic [32:0]             rank_ext;

   logic                             wr_en;
   logic [osm_pkg::IDX_W-1:0]        wr_addr;
   logic signed [osm_pkg::VAL_W-1:0] wr_val;
   logic [osm_pkg::CNT_W-1:0]        wr_cnt;

   // kth range check on the incoming word
   assign range_bad = (x_in < 32'sd1) ||
                      ({1'b0, x_in} > {{(33-osm_pkg::CNT_W){1'b0}}, total_ff});

   assign sum_ext = {1'b0, acc_ff} + {1'b0, rd_cnt_ff};
   assign k_ext   = {1'b0, x_ff[osm_pkg::CNT_W-1:0]};

   // scan evaluation and command load
   always_comb begin
      op_in    = op_ff;
      x_in_r   = x_ff;
      acc_in   = acc_ff;
      ans_in   = ans_ff;
      stat_in  = stat_ff;
      found_in = found_ff;
      pos_in   = pos_ff;
      eq_in    = eq_ff;
      eqcnt_in = eqcnt_ff;
      if (ctl.load) begin
         op_in    = cmd_in;
         x_in_r   = x_in;
         acc_in   = '0;
         found_in = 1'b0;
         pos_in   = used_ff;
         eq_in    = 1'b0;
         eqcnt_in = '0;
         stat_in  = osm_pkg::ST_OK;
         case (cmd_in)
            osm_pkg::CMD_PREV: ans_in = osm_pkg::NO_BELOW;
            osm_pkg::CMD_NEXT: ans_in = osm_pkg::NO_ABOVE;
            osm_pkg::CMD_KTH: begin
               ans_in = '0;
               if (range_bad) stat_in = osm_pkg::ST_RANGE;
            end
            default: ans_in = '0;
         endcase
      end else if (ctl.eval) begin
         case (op_ff)
            osm_pkg::CMD_RANK: begin
               if (rd_val_ff < x_ff) acc_in = sum_ext[osm_pkg::CNT_W-1:0];
            end
            osm_pkg::CMD_KTH: begin
               acc_in = sum_ext[osm_pkg::CNT_W-1:0];
               if (!found_ff && sum_ext >= k_ext) begin
                  ans_in   = rd_val_ff;
                  found_in = 1'b1;
               end
            end
            osm_pkg::CMD_PREV: begin
               if (rd_val_ff < x_ff) ans_in = rd_val_ff;
            end
            osm_pkg::CMD_NEXT: begin
               if (!found_ff && rd_val_ff > x_ff) begin
                  ans_in   = rd_val_ff;
                  found_in = 1'b1;
               end
            end
            osm_pkg::CMD_INSERT: begin
               if (!found_ff && rd_val_ff >= x_ff) begin
                  found_in = 1'b1;
                  pos_in   = ctl.eval_idx;
                  eq_in    = (rd_val_ff == x_ff);
                  eqcnt_in = rd_cnt_ff;
               end
            end
            default: ;
         endcase
      end else if (ctl.drop) begin
         stat_in = osm_pkg::ST_DROP;
      end
   end

   // table occupancy
   always_comb begin
      used_in  = used_ff;
      total_in = total_ff;
      if (ctl.bump || ctl.put) total_in = total_ff + 1'b1;
      if (ctl.put) used_in = used_ff + 1'b1;
   end

   // single write port per table
   always_comb begin
      wr_en   = ctl.shift_wr || ctl.bump || ctl.put;
      wr_addr = pos_ff[osm_pkg::IDX_W-1:0];
      wr_val  = x_ff;
      wr_cnt  = eqcnt_ff + 1'b1;
      if (ctl.shift_wr) begin
         wr_addr = ctl.wr_addr;
         wr_val  = rd_val_ff;
         wr_cnt  = rd_cnt_ff;
      end else if (ctl.put) begin
         wr_cnt = {{(osm_pkg::CNT_W-1){1'b0}}, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cnt_mem[wr_addr] <= wr_cnt;
         if (!ctl.bump) val_mem[wr_addr] <= wr_val;
      end
      if (ctl.rd_en) begin
         rd_val_ff <= val_mem[ctl.rd_addr];
         rd_cnt_ff <= cnt_mem[ctl.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         total_ff <= '0;
      end else begin
         used_ff  <= used_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      x_ff     <= x_in_r;
      acc_ff   <= acc_in;
      ans_ff   <= ans_in;
      stat_ff  <= stat_in;
      found_ff <= found_in;
      pos_ff   <= pos_in;
      eq_ff    <= eq_in;
      eqcnt_ff <= eqcnt_in;
   end

   // status back to the controller
   assign sts.used      = used_ff;
   assign sts.pos       = pos_ff;
   assign sts.is_insert = (op_ff == osm_pkg::CMD_INSERT);
   assign sts.ins_eq    = eq_ff;
   assign sts.ins_drop  = (total_ff == osm_pkg::CNT_MAX) ||
                          (eq_ff ? (eqcnt_ff == osm_pkg::CNT_MAX)
                                 : (used_ff == osm_pkg::USED_W'(osm_pkg::DIST_ENTRIES)));

   // result word
   assign rank_ext = {{(33-osm_pkg::CNT_W){1'b0}}, acc_ff} + 33'd1;
   always_comb begin
      if (stat_ff != osm_pkg::ST_OK) answer = '0;
      else if (op_ff == osm_pkg::CMD_RANK) answer = rank_ext[31:0];
      else answer = ans_ff;
   end
   assign status = stat_ff;

endmodule

// ----- sv/osm_ctrl.sv -----
// ----------------------------------------------------------------------------
// osm_ctrl
// sequencer: table scan, insert shift and result handshake
// ----------------------------------------------------------------------------
module osm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_fire,
   input  logic             rsp_fire,
   input  osm_pkg::sts_type sts,
   output osm_pkg::ctl_type ctl,
   output logic             idle,
   output logic             rsp_valid
);

   osm_pkg::state_type state_ff, state_in;
   logic [osm_pkg::USED_W-1:0] idx_ff, idx_in;
   logic [osm_pkg::USED_W-1:0] rdi_ff, rdi_in;
   logic                       rdv_ff, rdv_in;
   logic [osm_pkg::USED_W-1:0] idx_m1;

   assign idx_m1 = idx_ff - 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      rdi_in   = idx_ff;
      rdv_in   = 1'b0;
      case (state_ff)
         osm_pkg::S_IDLE: begin
            idx_in = '0;
            if (req_fire) state_in = osm_pkg::S_SCAN;
         end
         osm_pkg::S_SCAN: begin
            if (idx_ff < sts.used) begin
               rdv_in = 1'b1;
               idx_in = idx_ff + 1'b1;
            end else if (!rdv_ff) begin
               state_in = osm_pkg::S_DECIDE;
            end
         end
         osm_pkg::S_DECIDE: begin
            idx_in = sts.used;
            if (sts.is_insert && !sts.ins_drop && !sts.ins_eq)
               state_in = osm_pkg::S_SHIFT_RD;
            else
               state_in = osm_pkg::S_RESP;
         end
         osm_pkg::S_SHIFT_RD: begin
            if (idx_ff > sts.pos) state_in = osm_pkg::S_SHIFT_WR;
            else state_in = osm_pkg::S_RESP;
         end
         osm_pkg::S_SHIFT_WR: begin
            idx_in   = idx_m1;
            state_in = osm_pkg::S_SHIFT_RD;
         end
         osm_pkg::S_RESP: begin
            if (rsp_fire) state_in = osm_pkg::S_IDLE;
         end
         default: state_in = osm_pkg::S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      ctl          = '0;
      ctl.load     = req_fire;
      ctl.eval     = rdv_ff;
      ctl.eval_idx = rdi_ff;
      ctl.rd_addr  = idx_ff[osm_pkg::IDX_W-1:0];
      ctl.wr_addr  = idx_ff[osm_pkg::IDX_W-1:0];
      idle         = (state_ff == osm_pkg::S_IDLE);
      rsp_valid    = (state_ff == osm_pkg::S_RESP);
      case (state_ff)
         osm_pkg::S_SCAN: ctl.rd_en = (idx_ff < sts.used);
         osm_pkg::S_DECIDE: begin
            if (sts.is_insert) begin
               ctl.drop = sts.ins_drop;
               ctl.bump = !sts.ins_drop && sts.ins_eq;
            end
         end
         osm_pkg::S_SHIFT_RD: begin
            ctl.rd_addr = idx_m1[osm_pkg::IDX_W-1:0];
            ctl.rd_en   = (idx_ff > sts.pos);
            ctl.put     = !(idx_ff > sts.pos);
         end
         osm_pkg::S_SHIFT_WR: ctl.shift_wr = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= osm_pkg::S_IDLE;
         rdv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         rdv_ff   <= rdv_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      rdi_ff <= rdi_in;
   end

endmodule

// ----- sv/order_statistic_multiset_core.sv -----
// from accept to result word: a scan of every used entry, a decide step, then the result word
// a new insert also moves each entry above its place up one slot (read, write), then puts the value
// one word at a time; the next word is taken after the result word is accepted
// the rate is set by the one-entry-per-cycle scan of the tables and, on a new insert, by the shift
// reset clears the entry and element counts and the sequencer; no clearing pass
// ----------------------------------------------------------------------------
// order_statistic_multiset_core
// bounded sorted multiset of signed values with rank, kth, prev, next, insert
// ----------------------------------------------------------------------------
module order_statistic_multiset_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] operand_value
   input  logic [2:0]  req_tuser,   // [2:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] answer_value
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   osm_pkg::ctl_type ctl;
   osm_pkg::sts_type sts;
   logic             req_fire;
   logic             rsp_fire;
   logic             idle;

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign req_tready = idle;

   // sequencer
   osm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .rsp_fire  (rsp_fire),
      .sts       (sts),
      .ctl       (ctl),
      .idle      (idle),
      .rsp_valid (rsp_tvalid)
   );

   // tables and arithmetic
   osm_dpath u_dpath (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .cmd_in (req_tuser),
      .x_in   (req_tdata),
      .sts    (sts),
      .answer (rsp_tdata),
      .status (rsp_tuser)
   );

endmodule

// ----- sv/osm_chk.sv -----
// ----------------------------------------------------------------------------
// osm_chk
// port-level checks of the multiset core
// ----------------------------------------------------------------------------
module osm_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // result word held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word dropped or changed while stalled");

   // one word in flight at a time
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result is pending");

   // flagged results carry zero
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != osm_pkg::ST_OK |-> rsp_tdata == 32'd0)
      else $error("flagged result with nonzero answer");

   // status code in range
   a_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("bad status code");

   // no result word shown in the cycle after accept
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid)
      else $error("result shown in the cycle after accept");

endmodule

bind order_statistic_multiset_core osm_chk u_osm_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
